### hdl/psmb_pkg.sv
// Shared types, constants and trig helpers for the sky-map binner.
package psmb_pkg;

  localparam int unsigned NumPixDef    = 4096;
  localparam int unsigned AngleBitsDef = 16;

  localparam logic [1:0] REQ_ACC   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  localparam logic [1:0] REG_POL  = 2'd0;
  localparam logic [1:0] REG_WGT  = 2'd1;
  localparam logic [1:0] REG_SEN  = 2'd2;
  localparam logic [1:0] REG_WEN  = 2'd3;

  localparam logic signed [47:0] SatMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SatMin = {1'b1, {47{1'b0}}};

  typedef logic signed [47:0] val_t;

  // Request as it travels down the pipeline.
  typedef struct packed {
    logic        vld;
    logic [1:0]  req;
    logic [11:0] pix;
    logic [3:0]  comp;
    logic        last;
    logic        in_rng;
  } ctl_t;

  function automatic logic signed [16:0] qsine(input logic [14:0] x);
    logic signed [16:0] t [17];
    logic [3:0]         seg;
    logic [9:0]         frac;
    logic signed [16:0] d;
    logic signed [27:0] p;
    t = '{17'sd0, 17'sd3212, 17'sd6393, 17'sd9512, 17'sd12540, 17'sd15447,
          17'sd18205, 17'sd20788, 17'sd23170, 17'sd25330, 17'sd27245,
          17'sd28899, 17'sd30274, 17'sd31357, 17'sd32138, 17'sd32610,
          17'sd32767};
    seg  = x[13:10];
    frac = x[9:0];
    d    = t[seg + 5'd1] - t[seg];
    p    = 28'(d) * $signed({18'd0, frac}) + 28'sd512;
    if (x[14]) return 17'sd32767;
    return t[seg] + 17'(p >>> 10);
  endfunction

  function automatic logic signed [16:0] sine16(input logic [15:0] ph);
    logic [14:0]        pos;
    logic signed [16:0] v;
    pos = ph[15:14] == 2'b01 || ph[15:14] == 2'b11 ?
          15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    v = qsine(pos);
    return ph[15] ? -v : v;
  endfunction

  function automatic val_t sat_add(input val_t a, input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SatMax)) return SatMax;
    if (s < 65'(SatMin)) return SatMin;
    return val_t'(s);
  endfunction

endpackage

### hdl/psmb_terms.sv
// Increment datapath: trig lookup, products and rounding, over three register stages.
module psmb_terms #(
  parameter int unsigned AngleBits = psmb_pkg::AngleBitsDef
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [23:0]         sample_i,
  input  logic [AngleBits-1:0]       angle_i,
  input  logic [15:0]                weight_i,
  output logic signed [63:0]         inc_o [9]
);
  import psmb_pkg::*;

  logic [AngleBits-1:0] a2;
  logic [15:0]          ph;
  logic signed [16:0]   s_q, c_q;
  logic signed [40:0]   sw_q;
  logic signed [16:0]   w_q;
  logic signed [57:0]   swc_q, sws_q;
  logic signed [33:0]   wc_q, ws_q, cc_q, sc_q, ss_q;
  logic signed [40:0]   sw2_q;
  logic signed [16:0]   w2_q;

  assign a2 = AngleBits'({angle_i, 1'b0});
  always_comb begin
    if (AngleBits >= 16) ph = 16'(a2 >> (AngleBits - 16));
    else                 ph = 16'({a2, 16'd0} >> AngleBits);
  end

  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q  <= sine16(ph);
      c_q  <= sine16(16'(ph + 16'd16384));
      sw_q <= 41'(sample_i) * $signed({25'd0, weight_i});
      w_q  <= $signed({1'b0, weight_i});
    end
    swc_q <= 58'(sw_q) * 58'(c_q);
    sws_q <= 58'(sw_q) * 58'(s_q);
    wc_q  <= 34'(w_q) * 34'(c_q);
    ws_q  <= 34'(w_q) * 34'(s_q);
    cc_q  <= 34'(c_q) * 34'(c_q);
    sc_q  <= 34'(s_q) * 34'(c_q);
    ss_q  <= 34'(s_q) * 34'(s_q);
    sw2_q <= sw_q;
    w2_q  <= w_q;
  end

  always_ff @(posedge clk_i) begin
    inc_o[0] <= 64'(sw2_q);
    inc_o[1] <= rsh(64'(swc_q), 15);
    inc_o[2] <= rsh(64'(sws_q), 15);
    inc_o[3] <= 64'(w2_q);
    inc_o[4] <= rsh(64'(wc_q), 15);
    inc_o[5] <= rsh(64'(ws_q), 15);
    inc_o[6] <= rsh(64'(w2_q) * 64'(cc_q), 30);
    inc_o[7] <= rsh(64'(w2_q) * 64'(sc_q), 30);
    inc_o[8] <= rsh(64'(w2_q) * 64'(ss_q), 30);
  end

endmodule

### hdl/polarized_sky_map_binner.sv
// Top level: request pipeline, map memory with read-modify-write, result register.
// An item passes the control stages c1 to c4 and then the output register.
// Each item finishes its memory write-back before the next is taken; the busy counter
// and a pending result both hold off acceptance.
// Reset: control registers take their reset values; then a clearing pass zeroes
// every memory row, during which no item is accepted.
module polarized_sky_map_binner #(
  parameter int unsigned NumPix    = psmb_pkg::NumPixDef,
  parameter int unsigned AngleBits = psmb_pkg::AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // tdata: req_type[1:0], pixel[13:2], sample[37:14], angle[53:38], component[57:54]
  input  logic [63:0] s_tdata_i,
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // tdata: out_pixel[11:0], out_component[15:12], map_value[63:16]
  output logic [63:0] m_tdata_o,
  // tuser: kind
  output logic        m_tuser_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psmb_pkg::*;

  localparam int unsigned AW = (NumPix > 1) ? $clog2(NumPix) : 1;
  localparam int unsigned CW = $clog2(NumPix + 1);

  // Registers
  logic        pol_q;
  logic [15:0] wgt_q;
  logic        sen_q, wen_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= 1'b1; wgt_q <= 16'd256; sen_q <= 1'b1; wen_q <= 1'b1;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_POL: pol_q <= pwdata[0];
        REG_WGT: wgt_q <= pwdata[15:0];
        REG_SEN: sen_q <= pwdata[0];
        REG_WEN: wen_q <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_POL: prdata = {31'd0, pol_q};
      REG_WGT: prdata = {16'd0, wgt_q};
      REG_SEN: prdata = {31'd0, sen_q};
      REG_WEN: prdata = {31'd0, wen_q};
      default: prdata = '0;
    endcase
  end

  // Clearing pass and busy sequencing
  logic [CW-1:0] clr_q;
  logic          clr_act;
  logic [2:0]    busy_q;
  logic          obuf_q;
  ctl_t          c1_q, c2_q, c3_q, c4_q;
  logic          acc;
  assign clr_act   = clr_q != CW'(NumPix);
  assign s_tready_o = !clr_act && busy_q == 3'd0 && !obuf_q;
  assign acc = s_tvalid_i && s_tready_o;

  ctl_t cin;
  always_comb begin
    cin.vld    = acc;
    cin.req    = s_tdata_i[1:0];
    cin.pix    = s_tdata_i[13:2];
    cin.comp   = s_tdata_i[57:54];
    cin.last   = s_tlast_i;
    cin.in_rng = 32'(s_tdata_i[13:2]) < NumPix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; busy_q <= '0;
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0;
    end else begin
      if (clr_act) clr_q <= CW'(clr_q + 1'b1);
      if (acc) busy_q <= 3'd5;
      else if (busy_q != 3'd0) busy_q <= 3'(busy_q - 1'b1);
      c1_q <= cin;
      c2_q <= c1_q; c3_q <= c2_q; c4_q <= c3_q;
    end
  end

  logic signed [63:0] inc [9];
  psmb_terms #(.AngleBits(AngleBits)) u_terms (
    .clk_i(clk_i), .en_i(acc), .sample_i(s_tdata_i[37:14]),
    .angle_i(AngleBits'(s_tdata_i[53:38])), .weight_i(wgt_q), .inc_o(inc)
  );

  // Map memory: one row per pixel, nine 48-bit components per row.
  logic [431:0]  mem [NumPix];
  logic [431:0]  rd_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [431:0]  wdata;

  assign raddr = AW'(c3_q.pix);
  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // Stage 4: modify and write back.
  logic do_acc, do_clr, rd_ok;
  always_comb begin
    rd_ok  = c4_q.in_rng && c4_q.comp <= 4'd8;
    do_acc = c4_q.vld && c4_q.req == REQ_ACC && c4_q.in_rng;
    do_clr = c4_q.vld && c4_q.req == REQ_CLEAR && rd_ok;
    wdata  = rd_q;
    for (int k = 0; k < 9; k++) begin
      if (do_acc && ((k < 3 && sen_q) || (k >= 3 && wen_q)) &&
          (pol_q || k == 0 || k == 3))
        wdata[k*48 +: 48] = sat_add(rd_q[k*48 +: 48], inc[k]);
    end
    if (do_clr) wdata[c4_q.comp*48 +: 48] = '0;
    we    = clr_act || do_acc || do_clr;
    waddr = clr_act ? clr_q[AW-1:0] : AW'(c4_q.pix);
    if (clr_act) wdata = '0;
  end

  // Output register.
  logic [63:0] od_q;
  logic        ok_q;
  logic        emit;
  assign emit = c4_q.vld && ((c4_q.req == REQ_ACC && c4_q.last) ||
                c4_q.req == REQ_READ || c4_q.req == REQ_CLEAR);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) obuf_q <= 1'b0;
    else if (emit) obuf_q <= 1'b1;
    else if (m_tready_i) obuf_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ok_q <= c4_q.req == REQ_ACC ? KIND_ACK : KIND_DATA;
      od_q[11:0] <= c4_q.pix;
      od_q[15:12] <= c4_q.req == REQ_ACC ? 4'd0 : c4_q.comp;
      od_q[63:16] <= (c4_q.req != REQ_ACC && rd_ok) ? rd_q[c4_q.comp*48 +: 48] : 48'd0;
    end
  end
  assign m_tvalid_o = obuf_q;
  assign m_tdata_o  = od_q;
  assign m_tuser_o  = ok_q;

endmodule

### hdl/psmb_checker.sv
// Port-level checker for the binner, bound to the top level.
module psmb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [63:0] m_tdata_o,
  input logic        m_tuser_o
);
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o) else $error("item overlap");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result dropped");
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o[63:12] == 52'd0)
    else $error("ack carries data");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o) else $error("accept while result pending");
endmodule

bind polarized_sky_map_binner psmb_checker u_chk (.*);
